@@ hw/rtl/bf3_pkg.sv @@
// Package for the 3x3 box filter: field widths, register indexes and the
// reciprocal used to divide the window sum by nine. No dependencies.
`default_nettype none

package bf3_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 12;
  localparam int COORD_W = 11;
  localparam int SUM_W   = 12;
  localparam int IDX_W   = 2;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

  // floor(sum / 9) == (sum * 3641) >> 15 for every sum below 32768.
  localparam int DIV_RECIP_W = 12;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 12'd3641;
  localparam int DIV_SHIFT = 15;
  localparam int PROD_W    = SUM_W + DIV_RECIP_W;

  typedef enum logic [IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ hw/rtl/box_filter_3x3_mean_core.sv @@
// Top level of the 3x3 mean filter: counters, line store, window and output register.
// Depends on bf3_pkg and bf3_ram.
//
//   channel  ports                                   direction  beat carries
//   in       in_valid / in_ready                     sink       one raster-order pixel
//   out      out_valid / out_ready                   source     mean, center x/y, frame end
//   cfg      cfg_valid / cfg_ready                   sink       register index and data
//
// One pixel is taken every cycle unless the input stalls. The line store read is issued on
// the input beat and used in the middle stage, where the sum, the division by nine and the
// line store write happen in front of the output register. A stalled output holds the
// middle stage, and the input stalls only when both are full. Reset takes effect at once
// with no clearing pass: the line store entries that feed a result are always rewritten in
// the two rows before it. A frame width or height register write restarts the frame.
`default_nettype none

module box_filter_3x3_mean_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bf3_pkg::PIX_W-1:0]   in_pixel,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [bf3_pkg::PIX_W-1:0]   out_mean_value,
  output logic      [bf3_pkg::COORD_W-1:0] out_center_x,
  output logic      [bf3_pkg::COORD_W-1:0] out_center_y,
  output logic                             out_frame_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bf3_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [bf3_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
  localparam int PW     = bf3_pkg::PIX_W;

  logic [bf3_pkg::CFG_W-1:0] frame_width_r;
  logic [bf3_pkg::CFG_W-1:0] frame_height_r;
  logic [XW-1:0]             col_r;
  logic [YW-1:0]             row_r;
  logic                      cfg_fire;
  logic                      in_fire;
  logic                      mid_fire;

  logic [WEFF_W-1:0] w_eff;
  logic [WEFF_W-1:0] w_m1;
  logic [HEFF_W-1:0] h_eff;
  logic [HEFF_W-1:0] h_m1;
  logic              last_col;
  logic              last_row;

  logic              s1_valid_r;
  logic [PW-1:0]     s1_pixel_r;
  logic [XW-1:0]     s1_col_r;
  logic [YW-1:0]     s1_row_r;
  logic              s1_emit_r;
  logic              s1_last_r;

  logic [2*PW-1:0]   ram_rd_data;
  logic [PW-1:0]     top_pix;
  logic [PW-1:0]     mid_pix;
  logic [PW-1:0]     win_r [6];

  logic [bf3_pkg::SUM_W-1:0]  win_sum;
  logic [bf3_pkg::PROD_W-1:0] quot_prod;
  logic                       out_valid_r;
  logic [PW-1:0]              out_mean_r;
  logic [bf3_pkg::COORD_W-1:0] out_center_x_r;
  logic [bf3_pkg::COORD_W-1:0] out_center_y_r;
  logic                       out_frame_last_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign mid_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || mid_fire;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    if (frame_width_r < 12'd3) begin
      w_eff = WEFF_W'(3);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(frame_width_r);
    end
    if (frame_height_r < 12'd3) begin
      h_eff = HEFF_W'(3);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(frame_height_r);
    end
    w_m1     = w_eff - WEFF_W'(1);
    h_m1     = h_eff - HEFF_W'(1);
    last_col = (WEFF_W'(col_r) == w_m1);
    last_row = (HEFF_W'(row_r) == h_m1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bf3_pkg::RESET_FRAME_WIDTH;
      frame_height_r <= bf3_pkg::RESET_FRAME_HEIGHT;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        bf3_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        bf3_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_fire && (cfg_index == bf3_pkg::CFG_FRAME_WIDTH ||
                              cfg_index == bf3_pkg::CFG_FRAME_HEIGHT)) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + YW'(1);
      end else begin
        col_r <= col_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (mid_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel_r <= in_pixel;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_emit_r  <= (col_r >= XW'(2)) && (row_r >= YW'(2));
      s1_last_r  <= last_col && last_row;
    end
  end

  // Each word holds the pixel two rows up in the high byte and one row up in the low byte.
  bf3_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (mid_fire),
    .wr_addr (s1_col_r),
    .wr_data ({mid_pix, s1_pixel_r}),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (ram_rd_data)
  );

  assign top_pix = ram_rd_data[2*PW-1:PW];
  assign mid_pix = ram_rd_data[PW-1:0];

  always_comb begin
    win_sum = bf3_pkg::SUM_W'(top_pix) + bf3_pkg::SUM_W'(mid_pix)
            + bf3_pkg::SUM_W'(s1_pixel_r)
            + bf3_pkg::SUM_W'(win_r[0]) + bf3_pkg::SUM_W'(win_r[1])
            + bf3_pkg::SUM_W'(win_r[2]) + bf3_pkg::SUM_W'(win_r[3])
            + bf3_pkg::SUM_W'(win_r[4]) + bf3_pkg::SUM_W'(win_r[5]);
    quot_prod = bf3_pkg::PROD_W'(win_sum) * bf3_pkg::PROD_W'(bf3_pkg::DIV_RECIP);
  end

  always_ff @(posedge clk) begin
    if (mid_fire) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_pix;
      win_r[4] <= mid_pix;
      win_r[5] <= s1_pixel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mid_fire) begin
      out_valid_r <= s1_emit_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_fire) begin
      out_mean_r       <= quot_prod[bf3_pkg::DIV_SHIFT +: PW];
      out_center_x_r   <= bf3_pkg::COORD_W'(s1_col_r - XW'(1));
      out_center_y_r   <= bf3_pkg::COORD_W'(s1_row_r - YW'(1));
      out_frame_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;
  assign out_center_x   = out_center_x_r;
  assign out_center_y   = out_center_y_r;
  assign out_frame_last = out_frame_last_r;

endmodule

`default_nettype wire

@@ hw/rtl/bf3_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Self-contained; used for the filter's line store.
`default_nettype none

module bf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ verif/box_filter_3x3_mean_core_test.sv @@
// Self-checking testbench for box_filter_3x3_mean_core: it streams raster-order
// pixels, predicts every 3x3 mean with its own line stores and window, and checks
// each result beat. Depends on bf3_pkg and the RTL of the filter core.
module box_filter_3x3_mean_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM       = 2048;
  localparam int WINDOW_TAPS   = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int RESET_PIXELS  = 200;
  localparam int WIDE_PIXELS   = 100;
  localparam int TALL_ROWS     = 50;
  localparam int RANDOM_PIXELS = 700;
  localparam int MAX_REPORTS   = 30;

  localparam logic [bf3_pkg::IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [bf3_pkg::IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

  typedef struct packed {
    logic [bf3_pkg::PIX_W-1:0]   mean_value;
    logic [bf3_pkg::COORD_W-1:0] center_x;
    logic [bf3_pkg::COORD_W-1:0] center_y;
    logic                        frame_last;
  } mean_beat_t;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_PATTERN} rx_mode_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [bf3_pkg::PIX_W-1:0]   in_pixel;
  logic                        out_valid;
  logic                        out_ready;
  logic [bf3_pkg::PIX_W-1:0]   out_mean_value;
  logic [bf3_pkg::COORD_W-1:0] out_center_x;
  logic [bf3_pkg::COORD_W-1:0] out_center_y;
  logic                        out_frame_last;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [bf3_pkg::IDX_W-1:0]   cfg_index;
  logic [bf3_pkg::CFG_W-1:0]   cfg_wdata;

  logic [bf3_pkg::PIX_W-1:0] upper_row [MAX_DIM];
  logic [bf3_pkg::PIX_W-1:0] middle_row [MAX_DIM];
  logic [bf3_pkg::PIX_W-1:0] window_px [6];
  logic [bf3_pkg::CFG_W-1:0] width_reg;
  logic [bf3_pkg::CFG_W-1:0] height_reg;
  int unsigned               col_pos;
  int unsigned               row_pos;

  mean_beat_t pending_means [$];
  mean_beat_t expected_beat;

  int       errors;
  int       pixels_sent;
  int       means_checked;
  int       reg_writes;
  int       idle_cycles;
  int       burst_left;
  bit       tx_gaps;
  bit       hold_req;
  int       hold_left;
  int       mode_left;
  int       pattern_pos;
  rx_mode_t rx_mode;

  box_filter_3x3_mean_core #(
    .MAX_WIDTH(MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel(in_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mean_value(out_mean_value),
    .out_center_x(out_center_x),
    .out_center_y(out_center_y),
    .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [bf3_pkg::CFG_W-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void compute_window_mean(input logic [bf3_pkg::PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int unsigned sum;
    logic [bf3_pkg::PIX_W-1:0] top;
    logic [bf3_pkg::PIX_W-1:0] mid;
    mean_beat_t beat;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    x = (col_pos >= w) ? 0 : col_pos;
    y = (row_pos >= h) ? 0 : row_pos;
    top = upper_row[x];
    mid = middle_row[x];
    sum = top + mid + pix;
    foreach (window_px[k]) sum += window_px[k];
    if (x >= 2 && y >= 2) begin
      beat.mean_value = bf3_pkg::PIX_W'(sum / WINDOW_TAPS);
      beat.center_x = bf3_pkg::COORD_W'(x - 1);
      beat.center_y = bf3_pkg::COORD_W'(y - 1);
      beat.frame_last = (x == w - 1) && (y == h - 1);
      pending_means.push_back(beat);
    end
    upper_row[x] = mid;
    middle_row[x] = pix;
    window_px[0] = window_px[3];
    window_px[1] = window_px[4];
    window_px[2] = window_px[5];
    window_px[3] = top;
    window_px[4] = mid;
    window_px[5] = pix;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endfunction

  function automatic logic [bf3_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return bf3_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [bf3_pkg::PIX_W-1:0] pix);
    int gap;
    @(negedge clk);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_valid = 1'b1;
    in_pixel = pix;
    do @(posedge clk); while (!in_ready);
    compute_window_mean(pix);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bf3_pkg::IDX_W-1:0] idx,
                           input logic [bf3_pkg::CFG_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    if (idx == bf3_pkg::CFG_FRAME_WIDTH) begin
      width_reg = data;
      col_pos = 0;
      row_pos = 0;
    end else if (idx == bf3_pkg::CFG_FRAME_HEIGHT) begin
      height_reg = data;
      col_pos = 0;
      row_pos = 0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic report_mismatch(input string field, input int expected, input int actual);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, expected, actual);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t unexpected result: expected none, actual mean %0d at (%0d,%0d)",
                   $time, out_mean_value, out_center_x, out_center_y);
      end else begin
        expected_beat = pending_means.pop_front();
        means_checked++;
        if (out_mean_value !== expected_beat.mean_value)
          report_mismatch("mean_value", expected_beat.mean_value, out_mean_value);
        if (out_center_x !== expected_beat.center_x)
          report_mismatch("center_x", expected_beat.center_x, out_center_x);
        if (out_center_y !== expected_beat.center_y)
          report_mismatch("center_y", expected_beat.center_y, out_center_y);
        if (out_frame_last !== expected_beat.frame_last)
          report_mismatch("frame_last", expected_beat.frame_last, out_frame_last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    mode_left = 0;
    pattern_pos = 0;
    rx_mode = RX_ALWAYS;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (rx_mode)
          RX_ALWAYS: out_ready = 1'b1;
          RX_HALF: out_ready = 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready = ($urandom_range(0, 7) != 0);
          RX_PATTERN: begin
            out_ready = (pattern_pos < 3);
            pattern_pos = (pattern_pos + 1) % 5;
          end
        endcase
      end
    end
  end

  task automatic test_reset_geometry();
    tx_gaps = 1'b1;
    send_pixels(RESET_PIXELS);
  endtask

  task automatic test_directed_corners();
    tx_gaps = 1'b0;
    write_reg(bf3_pkg::CFG_FRAME_WIDTH, 12'd0);
    write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 12'd1);
    repeat (9) send_pixel(8'hFF);
    repeat (9) send_pixel(8'h00);
    write_reg(bf3_pkg::CFG_FRAME_WIDTH, 12'd2);
    send_pixel(8'hAA);
    send_pixel(8'h55);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    write_reg(CFG_IDX_SPARE2, 12'hFFF);
    write_reg(CFG_IDX_SPARE3, 12'h000);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    send_pixel(8'hFE);
    send_pixel(8'h00);
    send_pixel(8'hFF);
  endtask

  task automatic test_restart_midframe();
    tx_gaps = 1'b1;
    write_reg(bf3_pkg::CFG_FRAME_WIDTH, 12'd5);
    write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 12'd4);
    send_pixels(7);
    write_reg(bf3_pkg::CFG_FRAME_WIDTH, 12'd5);
    send_pixels(5 * 4 + 3);
  endtask

  task automatic test_largest_frames();
    tx_gaps = 1'b0;
    write_reg(bf3_pkg::CFG_FRAME_WIDTH, 12'hFFF);
    write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 12'd3);
    send_pixels(WIDE_PIXELS);
    write_reg(bf3_pkg::CFG_FRAME_WIDTH, 12'd3);
    write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 12'hFFF);
    send_pixels(3 * TALL_ROWS);
  endtask

  task automatic test_output_hold();
    tx_gaps = 1'b0;
    write_reg(bf3_pkg::CFG_FRAME_WIDTH, 12'd4);
    write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 12'd5);
    hold_req = 1'b1;
    wait (hold_left > 0);
    send_pixels(2 * 4 * 5);
  endtask

  task automatic test_random_frames();
    int start_count;
    logic [bf3_pkg::CFG_W-1:0] raw_w;
    logic [bf3_pkg::CFG_W-1:0] raw_h;
    int frames;
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: raw_w = bf3_pkg::CFG_W'($urandom_range(0, 2));
        1: raw_w = bf3_pkg::CFG_W'($urandom_range(11, 48));
        default: raw_w = bf3_pkg::CFG_W'($urandom_range(3, 10));
      endcase
      raw_h = ($urandom_range(0, 9) == 0) ? bf3_pkg::CFG_W'($urandom_range(0, 2))
                                          : bf3_pkg::CFG_W'($urandom_range(3, 8));
      write_reg(bf3_pkg::CFG_FRAME_WIDTH, raw_w);
      write_reg(bf3_pkg::CFG_FRAME_HEIGHT, raw_h);
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE2 : CFG_IDX_SPARE3,
                  bf3_pkg::CFG_W'($urandom_range(0, 4095)));
      tx_gaps = ($urandom_range(0, 3) != 0);
      frames = $urandom_range(1, 3);
      send_pixels(frames * int'(clamp_dim(raw_w) * clamp_dim(raw_h)));
      if ($urandom_range(0, 2) == 0)
        send_pixels(int'($urandom_range(1, 2 * clamp_dim(raw_w))));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = bf3_pkg::CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    hold_req = 1'b0;
    tx_gaps = 1'b0;
    burst_left = 0;
    errors = 0;
    pixels_sent = 0;
    means_checked = 0;
    reg_writes = 0;
    idle_cycles = 0;
    width_reg = bf3_pkg::RESET_FRAME_WIDTH;
    height_reg = bf3_pkg::RESET_FRAME_HEIGHT;
    col_pos = 0;
    row_pos = 0;
    foreach (upper_row[i]) upper_row[i] = '0;
    foreach (middle_row[i]) middle_row[i] = '0;
    foreach (window_px[i]) window_px[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_geometry();
    test_directed_corners();
    test_restart_midframe();
    test_largest_frames();
    test_output_hold();
    test_random_frames();
    wait_idle();

    $display("Run covered %0d pixels and %0d checked means over %0d register writes,",
             pixels_sent, means_checked, reg_writes);
    $display("including clamped frame sizes, restarts and a long output stall.");
    if (errors == 0 && pending_means.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bf3_pkg.sv
hw/rtl/bf3_ram.sv
hw/rtl/box_filter_3x3_mean_core.sv
verif/box_filter_3x3_mean_core_test.sv
